// ----- rtl/psfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package psfp_pkg;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [3:0] PH_HEADER    = 4'd0;
  localparam logic [3:0] PH_COMMAND   = 4'd1;
  localparam logic [3:0] PH_CMD_DELIM = 4'd2;
  localparam logic [3:0] PH_ADDR      = 4'd3;
  localparam logic [3:0] PH_FLAG1     = 4'd5;
  localparam logic [3:0] PH_FLAG5     = 4'd9;
  localparam logic [3:0] PH_TEMPLATE  = 4'd10;
  localparam logic [3:0] PH_TERM      = 4'd11;
  localparam logic [3:0] PH_DONE      = 4'd12;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_HEADER     = 4'd1;
  localparam logic [3:0] ERR_COMMAND    = 4'd2;
  localparam logic [3:0] ERR_CMD_DELIM  = 4'd3;
  localparam logic [3:0] ERR_FLAG1      = 4'd4;
  localparam logic [3:0] ERR_TEMPLATE   = 4'd9;
  localparam logic [3:0] ERR_TERMINATOR = 4'd10;
  localparam logic [3:0] ERR_INVALID    = 4'd11;

  localparam logic [1:0] AM_SKIP   = 2'd0;
  localparam logic [1:0] AM_DIGITS = 2'd1;
  localparam logic [1:0] AM_DONE   = 2'd2;

  localparam int NUM_FLAGS = 5;

  typedef logic [7:0] flag_array_t [NUM_FLAGS];

  function automatic logic [7:0] mark_of(input logic [3:0] ph);
    logic [7:0] m;
    case (ph)
      PH_HEADER, PH_TERM: m = CH_STAR;
      PH_COMMAND:         m = CH_S;
      default:            m = CH_BAR;
    endcase
    return m;
  endfunction

  function automatic logic [26:0] pack_status(input flag_array_t f);
    logic [7:0] f5;
    f5 = f[4];
    return {f[0][5:0], f[1][5:0], f[2][5:0], f[3][3:0],
            f5[5], f5[4], ~f5[3], f5[2], f5[0]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/printer_status_frame_parser.sv -----
// Printer status reply parser.
// The result of a reply is registered and appears in the cycle after its final byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the per-byte state update is a single registered step.
// in_ready stays high while the result register is empty or being taken.
// Reset (rst, synchronous, active high) clears the parse state and empties the result register.
`timescale 1ns / 1ps
`default_nettype none
module printer_status_frame_parser
  import psfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             parse_ok,
  output logic [3:0]       error_code,
  output logic [31:0]      unit_address,
  output logic [7:0]       template_id,
  output logic [26:0]      status_bits
);

  logic [3:0]  phase, phase_next;
  logic [1:0]  position, position_next;
  logic [1:0]  field_length, field_length_next;
  logic [7:0]  field_first, field_first_next;
  logic [31:0] address_accum, address_accum_next;
  logic [1:0]  address_mode, address_mode_next;
  flag_array_t flag_store, flag_store_next;
  logic [7:0]  template_byte, template_byte_next;
  logic [3:0]  error_latch, error_latch_next;
  logic        ended, ended_next;

  logic        in_fire;
  logic        is_digit, is_space;
  logic [3:0]  digit;
  logic [35:0] addr_prod;
  logic [31:0] addr_sat;
  logic [3:0]  mark_err;
  logic [3:0]  final_err;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_digit  = data_byte inside {[8'h30:8'h39]};
  assign is_space  = data_byte inside {CH_SPACE, [8'h09:8'h0D]};
  assign digit     = 4'(data_byte - CH_ZERO);
  assign addr_prod = {1'b0, address_accum, 3'b000} + {3'b000, address_accum, 1'b0}
                   + {32'd0, digit};
  assign addr_sat  = (|addr_prod[35:32]) ? 32'hFFFF_FFFF : addr_prod[31:0];

  always_comb begin
    phase_next         = phase;
    position_next      = (position == 2'd3) ? position : position + 2'd1;
    field_length_next  = field_length;
    field_first_next   = field_first;
    address_accum_next = address_accum;
    address_mode_next  = address_mode;
    flag_store_next    = flag_store;
    template_byte_next = template_byte;
    error_latch_next   = error_latch;
    ended_next         = ended;
    mark_err           = ERR_NONE;

    if (!ended && error_latch == ERR_NONE) begin
      if (data_byte == mark_of(phase)) begin
        case (phase)
          PH_HEADER: begin
            if (position != 2'd0 || field_length != 2'd0) mark_err = ERR_HEADER;
          end
          PH_COMMAND: begin
            if (position != 2'd1 || field_length != 2'd0) mark_err = ERR_COMMAND;
          end
          PH_CMD_DELIM: begin
            if (position != 2'd2 || field_length != 2'd0) mark_err = ERR_CMD_DELIM;
          end
          PH_TEMPLATE: begin
            if (field_length == 2'd0 || field_first != CH_P) mark_err = ERR_TEMPLATE;
            else if (field_length == 2'd1) template_byte_next = CH_BAR;
          end
          PH_TERM: begin
            if (field_length != 2'd0 || !final_byte) mark_err = ERR_TERMINATOR;
          end
          default: begin
            if (phase inside {[PH_FLAG1:PH_FLAG5]}) begin
              if (field_length != 2'd1) begin
                mark_err = ERR_FLAG1 + (phase - PH_FLAG1);
              end else begin
                for (int k = 0; k < NUM_FLAGS; k++) begin
                  if (phase == PH_FLAG1 + 4'(k)) flag_store_next[k] = field_first;
                end
              end
            end
          end
        endcase
        if (mark_err != ERR_NONE) begin
          error_latch_next = mark_err;
        end else begin
          phase_next        = phase + 4'd1;
          field_length_next = 2'd0;
          ended_next        = (phase == PH_TERM);
        end
      end else begin
        if (phase == PH_ADDR) begin
          case (address_mode)
            AM_SKIP: begin
              if (is_digit) begin
                address_accum_next = {28'd0, digit};
                address_mode_next  = AM_DIGITS;
              end else if (!is_space) begin
                address_mode_next = AM_DONE;
              end
            end
            AM_DIGITS: begin
              if (is_digit) address_accum_next = addr_sat;
              else address_mode_next = AM_DONE;
            end
            default: ;
          endcase
        end
        if (field_length == 2'd0) field_first_next = data_byte;
        else if (field_length == 2'd1 && phase == PH_TEMPLATE) template_byte_next = data_byte;
        if (field_length != 2'd3) field_length_next = field_length + 2'd1;
      end
    end

    final_err = error_latch_next;
    if (final_err == ERR_NONE && !ended_next) final_err = ERR_INVALID;
  end

  // Parse state; the final byte returns everything to the idle values.
  always_ff @(posedge clk) begin
    if (rst || (in_fire && final_byte)) begin
      phase         <= PH_HEADER;
      position      <= 2'd0;
      field_length  <= 2'd0;
      field_first   <= 8'd0;
      address_accum <= 32'd0;
      address_mode  <= AM_SKIP;
      for (int k = 0; k < NUM_FLAGS; k++) flag_store[k] <= 8'd0;
      template_byte <= CH_SPACE;
      error_latch   <= ERR_NONE;
      ended         <= 1'b0;
    end else if (in_fire) begin
      phase         <= phase_next;
      position      <= position_next;
      field_length  <= field_length_next;
      field_first   <= field_first_next;
      address_accum <= address_accum_next;
      address_mode  <= address_mode_next;
      flag_store    <= flag_store_next;
      template_byte <= template_byte_next;
      error_latch   <= error_latch_next;
      ended         <= ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && final_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Flags, address and template cannot change on a successful terminator byte.
  always_ff @(posedge clk) begin
    if (in_fire && final_byte) begin
      parse_ok   <= (final_err == ERR_NONE);
      error_code <= final_err;
      if (final_err == ERR_NONE) begin
        unit_address <= address_accum;
        template_id  <= template_byte;
        status_bits  <= pack_status(flag_store);
      end else begin
        unit_address <= 32'd0;
        template_id  <= 8'd0;
        status_bits  <= 27'd0;
      end
    end
  end

  a_ok_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_ok |-> error_code == ERR_NONE)
    else $error("parse_ok with nonzero error code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !parse_ok |-> unit_address == 32'd0 && template_id == 8'd0
                               && status_bits == 27'd0)
    else $error("failed reply carries nonzero fields");

  a_final_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && final_byte |=> out_valid)
    else $error("final byte gave no result");

  a_ended_phase: assert property (@(posedge clk) disable iff (rst)
    ended |-> phase == PH_DONE && error_latch == ERR_NONE)
    else $error("ended with wrong phase or error");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    !ended |-> phase <= PH_TERM)
    else $error("phase past terminator without end");

endmodule
`default_nettype wire

// ----- sim/printer_status_frame_parser_tb.sv -----
`timescale 1ns / 1ps
module printer_status_frame_parser_tb;
  import psfp_pkg::*;

  localparam int ITEMS      = 850;
  localparam int QUIET_TAIL = 120;
  localparam int LONG_HOLD  = 200;
  localparam int STUCK_MAX  = 2000;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct {
    bit        ok;
    bit [3:0]  err;
    bit [31:0] addr;
    bit [7:0]  tid;
    bit [26:0] status;
  } reply_t;

  typedef enum {CORRUPT, DROP, EXTRA, CUT, TRAIL} damage_t;

  class status_reply_scoreboard;
    bit [3:0]  phase;
    bit [1:0]  pos;
    bit [1:0]  flen;
    bit [7:0]  ffirst;
    bit [31:0] addr;
    bit [1:0]  amode;
    bit [7:0]  flags [NUM_FLAGS];
    bit [7:0]  tmpl;
    bit [3:0]  err_latch;
    bit        ended;
    reply_t    expected_replies [$];
    int unsigned failures;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = PH_HEADER;
      pos = 0;
      flen = 0;
      ffirst = 0;
      addr = 0;
      amode = AM_SKIP;
      foreach (flags[i]) flags[i] = 0;
      tmpl = CH_SPACE;
      err_latch = ERR_NONE;
      ended = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function bit [7:0] mark_for(bit [3:0] ph);
      if (ph == PH_HEADER || ph == PH_TERM)
        return CH_STAR;
      if (ph == PH_COMMAND)
        return CH_S;
      return CH_BAR;
    endfunction

    function void take_address(bit [7:0] b);
      bit digit;
      bit blank;
      longint unsigned wide;
      digit = b >= CH_ZERO && b <= CH_NINE;
      blank = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
      if (amode == AM_SKIP) begin
        if (blank)
          return;
        if (digit) begin
          addr = 32'(b - CH_ZERO);
          amode = AM_DIGITS;
        end else begin
          amode = AM_DONE;
        end
      end else if (amode == AM_DIGITS) begin
        if (digit) begin
          wide = addr;
          wide = wide * 10 + (b - CH_ZERO);
          addr = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end else begin
          amode = AM_DONE;
        end
      end
    endfunction

    function bit [3:0] check_mark(bit fin);
      case (phase)
        PH_HEADER:    return (pos == 0 && flen == 0) ? ERR_NONE : ERR_HEADER;
        PH_COMMAND:   return (pos == 1 && flen == 0) ? ERR_NONE : ERR_COMMAND;
        PH_CMD_DELIM: return (pos == 2 && flen == 0) ? ERR_NONE : ERR_CMD_DELIM;
        PH_TEMPLATE: begin
          if (flen == 0 || ffirst != CH_P)
            return ERR_TEMPLATE;
          if (flen == 1)
            tmpl = CH_BAR;
          return ERR_NONE;
        end
        PH_TERM:      return (flen == 0 && fin) ? ERR_NONE : ERR_TERMINATOR;
        default: begin
          if (phase >= PH_FLAG1 && phase <= PH_FLAG5) begin
            if (flen != 1)
              return ERR_FLAG1 + (phase - PH_FLAG1);
            flags[phase - PH_FLAG1] = ffirst;
          end
          return ERR_NONE;
        end
      endcase
    endfunction

    function void note_byte(bit [7:0] b, bit fin);
      bit [3:0] e;
      bit [7:0] f5;
      reply_t r;
      if (!ended && err_latch == ERR_NONE && phase < PH_DONE) begin
        if (b == mark_for(phase)) begin
          e = check_mark(fin);
          if (e != ERR_NONE) begin
            err_latch = e;
          end else begin
            phase++;
            flen = 0;
            if (phase >= PH_DONE)
              ended = 1;
          end
        end else begin
          if (phase == PH_ADDR)
            take_address(b);
          if (flen == 0)
            ffirst = b;
          else if (flen == 1 && phase == PH_TEMPLATE)
            tmpl = b;
          if (flen < 3)
            flen++;
        end
      end
      if (pos < 3)
        pos++;
      if (!fin)
        return;
      r.err = err_latch;
      if (r.err == ERR_NONE && !ended)
        r.err = ERR_INVALID;
      r.ok = r.err == ERR_NONE;
      r.addr = 0;
      r.tid = 0;
      r.status = 0;
      if (r.ok) begin
        f5 = flags[4];
        r.addr = addr;
        r.tid = tmpl;
        r.status = {flags[0][5:0], flags[1][5:0], flags[2][5:0], flags[3][3:0],
                    f5[5], f5[4], ~f5[3], f5[2], f5[0]};
      end
      expected_replies.push_back(r);
      clear_state();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_reply(logic ok, logic [3:0] code, logic [31:0] ua,
                              logic [7:0] tid, logic [26:0] status);
      reply_t r;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none expected: expected none actual ok=%b err=%0d",
                 $time, ok, code);
        failures++;
        return;
      end
      r = expected_replies.pop_front();
      compare_field("parse_ok", 32'(r.ok), 32'(ok));
      compare_field("error_code", 32'(r.err), 32'(code));
      compare_field("unit_address", r.addr, ua);
      compare_field("template_id", 32'(r.tid), 32'(tid));
      compare_field("status_bits", 32'(r.status), 32'(status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        parse_ok;
  logic [3:0]  error_code;
  logic [31:0] unit_address;
  logic [7:0]  template_id;
  logic [26:0] status_bits;

  status_reply_scoreboard parser_sb = new();
  bit [7:0] reply_q [$];
  int  bytes_sent = 0;
  bit  idle_on = 1'b0;
  bit  long_hold_start = 1'b0;
  int  ready_stall = 0;
  int  stuck_cycles = 0;

  printer_status_frame_parser dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      parser_sb.check_reply(parse_ok, error_code, unit_address, template_id, status_bits);
    if (long_hold_start) begin
      long_hold_start = 1'b0;
      ready_stall = LONG_HOLD;
    end
    if (ready_stall > 0) begin
      ready_stall--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_stall = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic void append(string s);
    for (int i = 0; i < s.len(); i++)
      reply_q.push_back(s[i]);
  endfunction

  function automatic void append_byte(bit [7:0] b);
    reply_q.push_back(b);
  endfunction

  function automatic bit [7:0] any_but(bit [7:0] x);
    bit [7:0] b;
    do
      b = 8'($urandom);
    while (b == x);
    return b;
  endfunction

  function automatic bit [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return CH_STAR;
      1: return CH_S;
      2: return CH_BAR;
      3: return CH_P;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [7:0] blank_byte();
    if ($urandom_range(0, 5) == 0)
      return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  task automatic send_byte(input bit [7:0] b, input bit fin);
    in_valid <= 1'b1;
    data_byte <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    parser_sb.note_byte(b, fin);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_reply();
    for (int i = 0; i < reply_q.size(); i++)
      send_byte(reply_q[i], i == reply_q.size() - 1);
    reply_q.delete();
  endtask

  task automatic send_directed();
    bit [7:0] extreme_flags [NUM_FLAGS] = '{8'h00, 8'hFF, 8'h3F, 8'hC0, 8'h37};
    append("*S|123|V1|A|B|C|D|E|PX|*");
    send_reply();
    // blanks before the address, top 32-bit value, bare template
    append("*S|");
    append_byte(CH_SPACE);
    append_byte(CH_TAB);
    append_byte(CH_CR);
    append("4294967295|v|");
    foreach (extreme_flags[i]) begin
      append_byte(extreme_flags[i]);
      append_byte(CH_BAR);
    end
    append("P|*");
    send_reply();
    append("*S| 99999999999|v|a|b|c|d|e|P");
    append_byte(8'hFF);
    append("|*");
    send_reply();
    append("*S|-5|v|a|b|c|d|e|Pq|*");
    send_reply();
    append("*S|12a34|777|a|b|c|d|e|Pqr|*");
    send_reply();
    append("*S||v|a|b|c|d|e|P1|*");
    send_reply();
    append("x*S|1|v|a|b|c|d|e|P1|*");
    send_reply();
    append("*xS|1|v|a|b|c|d|e|P1|*");
    send_reply();
    append("*Sx|1|v|a|b|c|d|e|P1|*");
    send_reply();
    append("*S|1|v||b|c|d|e|P1|*");
    send_reply();
    append("*S|1|v|a|bb|c|d|e|P1|*");
    send_reply();
    append("*S|1|v|a|b||d|e|P1|*");
    send_reply();
    append("*S|1|v|a|b|c|dd|e|P1|*");
    send_reply();
    append("*S|1|v|a|b|c|d|eee|P1|*");
    send_reply();
    append("*S|1|v|a|b|c|d|e|Q1|*");
    send_reply();
    append("*S|1|v|a|b|c|d|e||*");
    send_reply();
    append("*S|1|v|a|b|c|d|e|P1|*Z");
    send_reply();
    append("*S|1|v|a|b|c|d|e|P1|z*");
    send_reply();
    append("*S|1|v|a|b|c|d|e|P1|");
    send_reply();
    append("*");
    send_reply();
    append_byte(8'h00);
    send_reply();
  endtask

  task automatic send_random_reply();
    int n;
    int idx;
    damage_t dmg;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 24);
      repeat (n) append_byte(noise_byte());
    end else begin
      append("*S|");
      repeat ($urandom_range(0, 2)) append_byte(blank_byte());
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 5);
      repeat (n) append_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) append_byte(any_but(CH_BAR));
      append_byte(CH_BAR);
      repeat ($urandom_range(0, 3)) append_byte(any_but(CH_BAR));
      append_byte(CH_BAR);
      repeat (NUM_FLAGS) begin
        append_byte(any_but(CH_BAR));
        append_byte(CH_BAR);
      end
      append_byte(CH_P);
      repeat ($urandom_range(0, 2)) append_byte(any_but(CH_BAR));
      append_byte(CH_BAR);
      append_byte(CH_STAR);
      if ($urandom_range(0, 3) == 0) begin
        idx = $urandom_range(0, reply_q.size() - 1);
        dmg = damage_t'($urandom_range(0, 4));
        case (dmg)
          CORRUPT: reply_q[idx] = noise_byte();
          DROP:    reply_q.delete(idx);
          EXTRA:   reply_q.insert(idx, noise_byte());
          CUT:     reply_q = reply_q[0:idx];
          default: reply_q.push_back(noise_byte());
        endcase
      end
    end
    send_reply();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    send_directed();
    // receiver holds off so the block fills and backs up the input
    long_hold_start = 1'b1;
    while (bytes_sent < ITEMS) begin
      idle_on = (bytes_sent < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      send_random_reply();
    end
    idle_on = 1'b0;
    in_valid <= 1'b0;
    while (parser_sb.pending() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (parser_sb.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- printer_status_frame_parser.f -----
rtl/psfp_pkg.sv
rtl/printer_status_frame_parser.sv
sim/printer_status_frame_parser_tb.sv
